FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, off while in reset
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/drvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drvs_pkg;

	localparam int SAMPLE_COUNT = 16;

	localparam int ADC_W   = 12;
	localparam int LEVEL_W = 11;
	localparam int CV_SCALE = 1650;
	localparam int PROD_W  = ADC_W + LEVEL_W;

	localparam int CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int SUM_W = $clog2(SAMPLE_COUNT * 1649 + 1);
	localparam int CMP_W = LEVEL_W + 1 + $clog2(SAMPLE_COUNT + 1);

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_BREAK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SHORT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_LOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_LOW_HYS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_FULL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_FULL_HYS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_LOW    = 3'd6;

	localparam logic [LEVEL_W-1:0] RST_CELL_BREAK    = 11'd100;
	localparam logic [LEVEL_W-1:0] RST_CELL_SHORT    = 11'd10;
	localparam logic [LEVEL_W-1:0] RST_CELL_LOW      = 11'd1100;
	localparam logic [LEVEL_W-1:0] RST_CELL_LOW_HYS  = 11'd20;
	localparam logic [LEVEL_W-1:0] RST_CELL_FULL     = 11'd1350;
	localparam logic [LEVEL_W-1:0] RST_CELL_FULL_HYS = 11'd20;
	localparam logic [LEVEL_W-1:0] RST_SUPPLY_LOW    = 11'd1100;

	typedef enum logic [1:0] {
		COND_BREAK  = 2'd0,
		COND_SHORT  = 2'd1,
		COND_NORMAL = 2'd2
	} cell_cond_t;

	// centivolts from a raw 12-bit reading, truncated
	function automatic logic [LEVEL_W-1:0] to_centivolts(input logic [ADC_W-1:0] raw);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(raw) * PROD_W'(CV_SCALE);
		return prod[PROD_W-1:ADC_W];
	endfunction

	// level scaled to the accumulator domain, so sum compares stand for average compares
	function automatic logic [CMP_W-1:0] scale_level(input logic [LEVEL_W+1:0] level);
		return CMP_W'(level) * CMP_W'(SAMPLE_COUNT);
	endfunction

endpackage

`default_nettype wire

FILE: hdl/dual_rail_voltage_supervisor.sv
`timescale 1ns / 1ps
`default_nettype none

// Averaging supervisor for a backup cell and a main supply. Each sample transaction carries
// one 12-bit reading of each rail; both are scaled to centivolts and accumulated, and every
// SAMPLE_COUNT transactions the averages update the cell condition, the cell undervoltage
// and charge-full flags (with hysteresis) and the supply flag, with window_done marking that
// result. One result transaction leaves for every sample transaction, at one per clock cycle
// sustained unless result_stall holds the output; an input register feeds a single accumulate
// and compare stage that loads the result register. Averages are never divided out; the
// thresholds are scaled by SAMPLE_COUNT and compared against the sums. Configuration
// registers are written through cfg_wr_en, cfg_index and cfg_data; indexes above 6 are ignored.

`include "assert_macros.svh"

module dual_rail_voltage_supervisor import drvs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LEVEL_W-1:0]   cfg_data,
	input  wire logic                 sample_valid,
	output logic                      sample_stall,
	input  wire logic [ADC_W-1:0]     cell_sample,
	input  wire logic [ADC_W-1:0]     supply_sample,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      supply_ok,
	output logic                      cell_ok,
	output logic                      cell_full,
	output logic [1:0]                cell_condition,
	output logic                      window_done
);

	logic [LEVEL_W-1:0] cell_break_q, cell_short_q, cell_low_q, cell_low_hys_q;
	logic [LEVEL_W-1:0] cell_full_lvl_q, cell_full_hys_q, supply_low_q;

	logic               valid_s1;
	logic [ADC_W-1:0]   cell_sample_s1, supply_sample_s1;

	logic [CNT_W-1:0]   tick_count_q;
	logic [SUM_W-1:0]   cell_sum_q, supply_sum_q;
	logic               supply_ok_q, cell_ok_q, cell_full_q, window_done_q, result_valid_q;
	cell_cond_t         cell_status_q;

	logic               advance, last_tick;
	logic [SUM_W-1:0]   cell_sum_new, supply_sum_new;
	logic [CMP_W-1:0]   cell_cmp, supply_cmp;
	logic               le_break, ge_short;
	logic               low_set, low_clr, full_set, full_clr, supply_ge;
	logic               cell_ok_new, cell_full_new;
	cell_cond_t         cell_status_new;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_break_q    <= RST_CELL_BREAK;
			cell_short_q    <= RST_CELL_SHORT;
			cell_low_q      <= RST_CELL_LOW;
			cell_low_hys_q  <= RST_CELL_LOW_HYS;
			cell_full_lvl_q <= RST_CELL_FULL;
			cell_full_hys_q <= RST_CELL_FULL_HYS;
			supply_low_q    <= RST_SUPPLY_LOW;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CELL_BREAK:    cell_break_q    <= cfg_data;
				REG_CELL_SHORT:    cell_short_q    <= cfg_data;
				REG_CELL_LOW:      cell_low_q      <= cfg_data;
				REG_CELL_LOW_HYS:  cell_low_hys_q  <= cfg_data;
				REG_CELL_FULL:     cell_full_lvl_q <= cfg_data;
				REG_CELL_FULL_HYS: cell_full_hys_q <= cfg_data;
				REG_SUPPLY_LOW:    supply_low_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			cell_sample_s1   <= cell_sample;
			supply_sample_s1 <= supply_sample;
		end
	end

	// accumulate and decide
	always_comb begin
		last_tick      = (tick_count_q == CNT_W'(SAMPLE_COUNT - 1));
		cell_sum_new   = cell_sum_q + SUM_W'(to_centivolts(cell_sample_s1));
		supply_sum_new = supply_sum_q + SUM_W'(to_centivolts(supply_sample_s1));
		cell_cmp       = CMP_W'(cell_sum_new);
		supply_cmp     = CMP_W'(supply_sum_new);

		le_break  = cell_cmp < scale_level({2'b00, cell_break_q} + 13'd1);
		ge_short  = cell_cmp >= scale_level({2'b00, cell_short_q});
		supply_ge = supply_cmp >= scale_level({2'b00, supply_low_q});

		low_set  = cell_cmp >= scale_level({2'b00, cell_low_q} + {2'b00, cell_low_hys_q});
		low_clr  = (cell_low_q >= cell_low_hys_q)
			&& (cell_cmp < scale_level({2'b00, cell_low_q} - {2'b00, cell_low_hys_q} + 13'd1));
		full_set = cell_cmp >= scale_level({2'b00, cell_full_lvl_q} + {2'b00, cell_full_hys_q});
		full_clr = (cell_full_lvl_q >= cell_full_hys_q)
			&& (cell_cmp < scale_level({2'b00, cell_full_lvl_q} - {2'b00, cell_full_hys_q}
				+ 13'd1));

		cell_ok_new   = cell_ok_q ? !low_clr : low_set;
		cell_full_new = cell_full_q ? !full_clr : full_set;

		if (le_break && ge_short) begin
			cell_status_new = COND_BREAK;
		end else if (!ge_short) begin
			cell_status_new = COND_SHORT;
		end else begin
			cell_status_new = COND_NORMAL;
		end
	end

	// window state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= '0;
			cell_sum_q     <= '0;
			supply_sum_q   <= '0;
			supply_ok_q    <= 1'b1;
			cell_ok_q      <= 1'b1;
			cell_full_q    <= 1'b1;
			cell_status_q  <= COND_NORMAL;
			window_done_q  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!result_valid_q || !result_stall) begin
				result_valid_q <= valid_s1;
			end
			if (advance) begin
				window_done_q <= last_tick;
				if (last_tick) begin
					tick_count_q  <= '0;
					cell_sum_q    <= '0;
					supply_sum_q  <= '0;
					supply_ok_q   <= supply_ge;
					cell_ok_q     <= cell_ok_new;
					cell_full_q   <= cell_full_new;
					cell_status_q <= cell_status_new;
				end else begin
					tick_count_q <= tick_count_q + CNT_W'(1);
					cell_sum_q   <= cell_sum_new;
					supply_sum_q <= supply_sum_new;
				end
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign supply_ok      = supply_ok_q;
	assign cell_ok        = cell_ok_q;
	assign cell_full      = cell_full_q;
	assign cell_condition = cell_status_q;
	assign window_done    = window_done_q;

	`ASSERT_NOW(a_stall_needs_item, sample_stall, valid_s1, "stall without a held transaction")
	`ASSERT_NOW(a_done_clears_count, result_valid && window_done,
		tick_count_q == '0 && cell_sum_q == '0 && supply_sum_q == '0,
		"window closed but accumulators not cleared")
	`ASSERT_NEXT(a_count_steps, advance && !last_tick,
		tick_count_q == $past(tick_count_q) + CNT_W'(1), "tick count did not step")
	`ASSERT_NEXT(a_flags_hold, !advance,
		$stable(cell_ok_q) && $stable(cell_full_q) && $stable(supply_ok_q)
		&& $stable(cell_status_q) && $stable(cell_sum_q),
		"window state changed without a transaction")

endmodule

`default_nettype wire
